[hdl/rgo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial glow overlay package
// Widths, constants, item types and the exp(-e) table builder that the
// pipeline modules share.
// ----------------------------------------------------------------------------
package rgo_pkg;

  localparam int COORD_BITS      = 12;
  localparam int EXP_TABLE_DEPTH = 1024;
  localparam int IDX_BITS        = $clog2(EXP_TABLE_DEPTH);

  localparam int COLOR_BITS = 8;
  localparam int FIELD_BITS = 12;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int D2_BITS    = SQ_BITS + 1;
  localparam int SCALE_BITS = 32;
  localparam int P_BITS     = D2_BITS + SCALE_BITS;
  localparam int EXP_SAT_BIT = 36;

  localparam int ROM_BITS   = 16;
  localparam int PEAK_BITS  = 16;
  localparam int GLOW_BITS  = ROM_BITS + PEAK_BITS;
  localparam int GLOW_FRAC  = 24;

  localparam int NOISE_DEN  = 100000;
  localparam int NOISE_MID  = 2000;
  localparam int NOISE_GAIN = 255;
  localparam int NOISE_BITS = FIELD_BITS + 1;
  localparam int NPROD_BITS = 21;
  localparam int NREM_BITS  = 17;
  localparam int NQ_BITS    = 4;
  localparam int NQ_MIN     = -6;
  localparam int NQ_STEPS   = 5;
  localparam int PROD_BITS  = GLOW_FRAC + NREM_BITS;
  localparam int LEVEL_BITS = 11;
  localparam int LEVEL_MAX  = 255;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FALLOFF_SCALE = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GLOW_PEAK     = 3'd3;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic [FIELD_BITS-1:0] x;
    logic [FIELD_BITS-1:0] y;
    logic [FIELD_BITS-1:0] noise;
  } pixel_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] center_x;
    logic [FIELD_BITS-1:0] center_y;
    logic [SCALE_BITS-1:0] falloff_scale;
    logic [PEAK_BITS-1:0]  glow_peak;
  } cfg_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0]        gray;
    logic [D2_BITS-1:0]           d2;
    logic signed [NQ_BITS-1:0]    nq;
    logic signed [NPROD_BITS-1:0] nprod;
  } front_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0]     gray;
    logic [GLOW_BITS-1:0]      glow;
    logic signed [NQ_BITS-1:0] nq;
    logic [NREM_BITS-1:0]      nthresh;
  } glow_t;

  typedef logic [ROM_BITS-1:0] exp_rom_t [EXP_TABLE_DEPTH];

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  // Division of a series term by its step number, one fixed divisor per step.
  function automatic logic [63:0] div_step(input logic [63:0] x, input int k);
    logic [63:0] r;
    case (k)
      1:       r = x;
      2:       r = x / 2;
      3:       r = x / 3;
      4:       r = x / 4;
      5:       r = x / 5;
      6:       r = x / 6;
      7:       r = x / 7;
      8:       r = x / 8;
      9:       r = x / 9;
      10:      r = x / 10;
      11:      r = x / 11;
      12:      r = x / 12;
      13:      r = x / 13;
      14:      r = x / 14;
      15:      r = x / 15;
      16:      r = x / 16;
      17:      r = x / 17;
      18:      r = x / 18;
      19:      r = x / 19;
      20:      r = x / 20;
      21:      r = x / 21;
      22:      r = x / 22;
      23:      r = x / 23;
      24:      r = x / 24;
      default: r = x;
    endcase
    return r;
  endfunction

  // exp(-f) for f in Q2.30 between zero and one, alternating Taylor series.
  function automatic logic [63:0] exp_neg_unit(input logic [63:0] f);
    logic [63:0] term;
    logic [63:0] sum;
    term = ONE_Q30;
    sum  = ONE_Q30;
    for (int k = 1; k <= 24; k++) begin
      term = div_step((term * f) >> 30, k);
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Entry i holds exp(-16*i/depth) in Q0.16, saturated at all ones.
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] e1;
    logic [63:0] x;
    logic [63:0] n;
    logic [63:0] v;
    logic [63:0] q;
    e1 = exp_neg_unit(ONE_Q30);
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      x = 64'(i) << (34 - IDX_BITS);
      n = x >> 30;
      v = exp_neg_unit(x & (ONE_Q30 - 64'd1));
      for (int j = 0; j < 16; j++) begin
        if (64'(j) < n) begin
          v = (v * e1 + (ONE_Q30 >> 1)) >> 30;
        end
      end
      q = (v + 64'd8192) >> 14;
      if (q > 64'd65535) begin
        q = 64'd65535;
      end
      rom[i] = q[ROM_BITS-1:0];
    end
    return rom;
  endfunction

endpackage

[hdl/rgo_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial glow front stages
// Gray level, squared distance to the glow center and the integer part of
// the noise offset, over three register stages.
// ----------------------------------------------------------------------------
module rgo_front
  import rgo_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   in_valid,
  output logic   in_stall,
  input  pixel_t in_item,
  output logic   out_valid,
  input  logic   out_stall,
  output front_t out_item
);

  localparam int STAGES = 3;

  logic [STAGES-1:0] v;
  logic [STAGES-1:0] en;

  logic [COLOR_BITS-1:0]        s1_gray;
  coord_t                       s1_adx;
  coord_t                       s1_ady;
  logic signed [NOISE_BITS-1:0] s1_n;

  logic [COLOR_BITS-1:0]        s2_gray;
  logic [SQ_BITS-1:0]           s2_sqx;
  logic [SQ_BITS-1:0]           s2_sqy;
  logic signed [NPROD_BITS-1:0] s2_nprod;

  logic [12:0]                  gray_sum;
  coord_t                       px;
  coord_t                       py;
  coord_t                       cx;
  coord_t                       cy;
  logic signed [NPROD_BITS-1:0] n_ext;
  logic [NQ_BITS-1:0]           cnt;

  always_comb begin
    en[STAGES-1] = !v[STAGES-1] || !out_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[STAGES-1];

  always_comb begin
    gray_sum = 13'd11 * 13'(in_item.red) + 13'd16 * 13'(in_item.green)
             + 13'd5 * 13'(in_item.blue);
    px = coord_t'(in_item.x);
    py = coord_t'(in_item.y);
    cx = coord_t'(cfg.center_x);
    cy = coord_t'(cfg.center_y);
    n_ext = NPROD_BITS'(s1_n);
    // Thresholds at every multiple of the noise denominator give floor().
    cnt = '0;
    for (int k = -NQ_STEPS; k <= NQ_STEPS; k++) begin
      if (s2_nprod >= NPROD_BITS'(k * NOISE_DEN)) begin
        cnt = cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (en[i]) begin
          v[i] <= (i == 0) ? in_valid : v[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_gray <= gray_sum[12:5];
      s1_adx  <= (px >= cx) ? px - cx : cx - px;
      s1_ady  <= (py >= cy) ? py - cy : cy - py;
      s1_n    <= $signed({1'b0, in_item.noise}) - $signed(NOISE_BITS'(NOISE_MID));
    end
    if (en[1]) begin
      s2_gray  <= s1_gray;
      s2_sqx   <= SQ_BITS'(s1_adx) * SQ_BITS'(s1_adx);
      s2_sqy   <= SQ_BITS'(s1_ady) * SQ_BITS'(s1_ady);
      s2_nprod <= n_ext * $signed(NPROD_BITS'(NOISE_GAIN));
    end
    if (en[2]) begin
      out_item.gray  <= s2_gray;
      out_item.d2    <= D2_BITS'(s2_sqx) + D2_BITS'(s2_sqy);
      out_item.nq    <= $signed(cnt) + $signed(NQ_BITS'(NQ_MIN));
      out_item.nprod <= s2_nprod;
    end
  end

endmodule

[hdl/rgo_glow.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial glow falloff stages
// Exponent product, exp(-e) table read and glow scaling, over three register
// stages. The noise remainder travels alongside.
// ----------------------------------------------------------------------------
module rgo_glow
  import rgo_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   in_valid,
  output logic   in_stall,
  input  front_t in_item,
  output logic   out_valid,
  input  logic   out_stall,
  output glow_t  out_item
);

  localparam int STAGES = 3;
  localparam exp_rom_t EXP_ROM = build_exp_rom();

  logic [STAGES-1:0] v;
  logic [STAGES-1:0] en;

  logic [P_BITS-1:0]         s4_p;
  logic [COLOR_BITS-1:0]     s4_gray;
  logic signed [NQ_BITS-1:0] s4_nq;
  logic [NREM_BITS-1:0]      s4_nrem;

  logic [ROM_BITS-1:0]       s5_rom;
  logic [COLOR_BITS-1:0]     s5_gray;
  logic signed [NQ_BITS-1:0] s5_nq;
  logic [NREM_BITS-1:0]      s5_nrem;

  logic signed [NPROD_BITS-1:0] nq_ext;
  logic signed [NPROD_BITS-1:0] nrem_full;
  logic                         sat;
  logic [IDX_BITS-1:0]          idx;

  always_comb begin
    en[STAGES-1] = !v[STAGES-1] || !out_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[STAGES-1];

  always_comb begin
    nq_ext    = NPROD_BITS'(in_item.nq);
    nrem_full = in_item.nprod - nq_ext * $signed(NPROD_BITS'(NOISE_DEN));
    // An exponent of sixteen or more gives no glow at all.
    sat = |s4_p[P_BITS-1:EXP_SAT_BIT];
    idx = s4_p[EXP_SAT_BIT-1 -: IDX_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (en[i]) begin
          v[i] <= (i == 0) ? in_valid : v[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s4_p    <= P_BITS'(in_item.d2) * P_BITS'(cfg.falloff_scale);
      s4_gray <= in_item.gray;
      s4_nq   <= in_item.nq;
      s4_nrem <= nrem_full[NREM_BITS-1:0];
    end
    if (en[1]) begin
      s5_rom  <= sat ? '0 : EXP_ROM[idx];
      s5_gray <= s4_gray;
      s5_nq   <= s4_nq;
      s5_nrem <= s4_nrem;
    end
    if (en[2]) begin
      out_item.gray    <= s5_gray;
      out_item.glow    <= GLOW_BITS'(s5_rom) * GLOW_BITS'(cfg.glow_peak);
      out_item.nq      <= s5_nq;
      out_item.nthresh <= NREM_BITS'(NOISE_DEN) - s5_nrem;
    end
  end

endmodule

[hdl/rgo_mix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial glow mixing stages
// Adds gray, glow and noise, settles the carry from both fractions and
// clamps the level, over two register stages.
// ----------------------------------------------------------------------------
module rgo_mix
  import rgo_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  glow_t                 in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COLOR_BITS-1:0] out_level
);

  localparam int STAGES = 2;

  logic [STAGES-1:0] v;
  logic [STAGES-1:0] en;

  logic [PROD_BITS-1:0]         s7_prod;
  logic signed [LEVEL_BITS-1:0] s7_base;
  logic [NREM_BITS-1:0]         s7_thresh;

  logic signed [LEVEL_BITS-1:0] base;
  logic                         carry;
  logic signed [LEVEL_BITS-1:0] level;

  always_comb begin
    en[STAGES-1] = !v[STAGES-1] || !out_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[STAGES-1];

  always_comb begin
    base = $signed({3'b000, in_item.gray})
         + $signed({3'b000, in_item.glow[GLOW_BITS-1:GLOW_FRAC]})
         + LEVEL_BITS'(in_item.nq);
    // The two fractions reach one when frac/2^24 >= (den - rem)/den.
    carry = s7_prod >= {s7_thresh, {GLOW_FRAC{1'b0}}};
    level = s7_base + $signed({{(LEVEL_BITS-1){1'b0}}, carry});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (en[i]) begin
          v[i] <= (i == 0) ? in_valid : v[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s7_prod   <= PROD_BITS'(in_item.glow[GLOW_FRAC-1:0]) * PROD_BITS'(NOISE_DEN);
      s7_base   <= base;
      s7_thresh <= in_item.nthresh;
    end
    if (en[1]) begin
      if (level < 0) begin
        out_level <= '0;
      end else if (level > LEVEL_BITS'(LEVEL_MAX)) begin
        out_level <= COLOR_BITS'(LEVEL_MAX);
      end else begin
        out_level <= level[COLOR_BITS-1:0];
      end
    end
  end

endmodule

[hdl/radial_glow_overlay_pixel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial glow overlay, pixel stream
// Converts each pixel to gray, adds a Gaussian-shaped glow around a
// configured center and a small noise offset, and clamps to 0..255.
// ----------------------------------------------------------------------------
// The block takes one pixel item per clock while its input is not stalled
// and returns one gray item per pixel, in order, through eight register
// stages (three for gray, distance and noise split, three for the exponent
// product, the registered exp(-e) table read and the glow product, two for
// the final sum and clamp). Each stage only holds when the one after it is
// full and blocked, so a stall on the output fills empty stages before the
// input is stalled. Configuration registers are written through cfg_write,
// cfg_index and cfg_data; the user must write them only while no item is in
// flight, as the block itself does not enforce this. An index beyond the
// four registers is ignored and data is cut to each register's width.

module radial_glow_overlay_pixel
  import rgo_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [COLOR_BITS-1:0]     pixel_red,
  input  logic [COLOR_BITS-1:0]     pixel_green,
  input  logic [COLOR_BITS-1:0]     pixel_blue,
  input  logic [FIELD_BITS-1:0]     pixel_x,
  input  logic [FIELD_BITS-1:0]     pixel_y,
  input  logic [FIELD_BITS-1:0]     noise_code,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [COLOR_BITS-1:0]     gray_out
);

  cfg_t   cfg;
  pixel_t pixel;
  front_t front_item;
  glow_t  glow_item;
  logic   front_valid;
  logic   front_stall;
  logic   glow_valid;
  logic   glow_stall;

  // Register file; all four registers reset to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CENTER_X:      cfg.center_x      <= cfg_data[FIELD_BITS-1:0];
        REG_CENTER_Y:      cfg.center_y      <= cfg_data[FIELD_BITS-1:0];
        REG_FALLOFF_SCALE: cfg.falloff_scale <= cfg_data[SCALE_BITS-1:0];
        REG_GLOW_PEAK:     cfg.glow_peak     <= cfg_data[PEAK_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign pixel = '{red: pixel_red, green: pixel_green, blue: pixel_blue,
                   x: pixel_x, y: pixel_y, noise: noise_code};

  // Gray level, squared distance and the whole part of the noise offset.
  rgo_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (pixel),
    .out_valid (front_valid),
    .out_stall (front_stall),
    .out_item  (front_item)
  );

  // Exponent, table read and glow scaled by the peak.
  rgo_glow u_glow (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (front_valid),
    .in_stall  (front_stall),
    .in_item   (front_item),
    .out_valid (glow_valid),
    .out_stall (glow_stall),
    .out_item  (glow_item)
  );

  // Sum with exact truncation, then clamp into the output register.
  rgo_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (glow_valid),
    .in_stall  (glow_stall),
    .in_item   (glow_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_level (gray_out)
  );

endmodule

[hdl/rgo_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial glow port checker
// Watches the top level's ports for reset, hold and latency behavior.
// ----------------------------------------------------------------------------
module rgo_checker
  import rgo_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COLOR_BITS-1:0] gray_out
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // A waiting result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(gray_out))
    else $error("stalled result changed or vanished");

  // An accepted item reaches the output if the output does not stall on its way.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
    ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("item did not arrive after eight free cycles");

  // An empty output with no stall never pushes back on the input.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !out_stall |-> !in_stall)
    else $error("input stalled with the output free and empty");

endmodule

bind radial_glow_overlay_pixel rgo_checker u_checker (.*);

[tb/radial_glow_overlay_pixel_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial glow overlay pixel regression
// Drives pixel items into the glow overlay under random source gaps and sink
// stalls. Each gray item that comes out is checked against a bit-exact
// software predictor of the gray, distance, exp(-e) falloff and noise path.
// The run covers several register settings and reports every mismatch.
// ----------------------------------------------------------------------------

module radial_glow_overlay_pixel_test;
  import rgo_pkg::*;

  typedef longint unsigned u64_t;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 11;
  // Eight register stages between an accepted pixel and its gray item.
  localparam int PIPE_DEPTH   = 8;
  localparam int IDLE_PERCENT = 31;
  localparam int DRAIN_LIMIT  = 5000;

  localparam u64_t   Q30_ONE        = 64'd1 << 30;
  localparam u64_t   EXP_SATURATION = 64'd1 << 36;
  localparam longint GLOW_ONE       = 64'sd1 << 24;
  localparam longint NOISE_SPAN     = 100000;
  localparam longint NOISE_ZERO     = 2000;
  localparam longint GRAY_MAX       = 255;

  localparam logic [FIELD_BITS-1:0] COORD_MAX   = '1;
  localparam logic [FIELD_BITS-1:0] NOISE_NONE  = 12'd2000;
  localparam logic [FIELD_BITS-1:0] NOISE_TOP   = 12'd4000;
  localparam logic [COLOR_BITS-1:0] COLOR_FULL  = '1;
  localparam logic [SCALE_BITS-1:0] SCALE_MAX   = '1;
  localparam logic [PEAK_BITS-1:0]  PEAK_MAX    = '1;

  // One pixel item that is in flight, with the gray level it must produce.
  typedef struct {
    int                    serial;
    pixel_t                px;
    logic [COLOR_BITS-1:0] gray;
  } gray_expect_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [COLOR_BITS-1:0]     pixel_red = '0;
  logic [COLOR_BITS-1:0]     pixel_green = '0;
  logic [COLOR_BITS-1:0]     pixel_blue = '0;
  logic [FIELD_BITS-1:0]     pixel_x = '0;
  logic [FIELD_BITS-1:0]     pixel_y = '0;
  logic [FIELD_BITS-1:0]     noise_code = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [COLOR_BITS-1:0]     gray_out;

  // The predictor's own copy of the registers and of the falloff table.
  cfg_t                      glow_cfg = '0;
  logic [ROM_BITS-1:0]       falloff_table [EXP_TABLE_DEPTH];

  gray_expect_t              gray_expected_q [$];
  // While low, neither the source nor the sink ever idles.
  bit                        pace_idle = 1'b1;
  int                        items_sent = 0;
  int                        results_seen = 0;
  int                        settings_applied = 0;
  int                        mismatches = 0;

  radial_glow_overlay_pixel i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_red   (pixel_red),
    .pixel_green (pixel_green),
    .pixel_blue  (pixel_blue),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .noise_code  (noise_code),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .gray_out    (gray_out)
  );

  initial begin
    forever begin
      #(CLK_PERIOD / 2) clk = ~clk;
    end
  end

  // exp(-f) for a Q2.30 fraction f in 0..1, as an alternating Taylor series
  // with every term truncated. The sum wraps like plain unsigned arithmetic.
  function automatic u64_t exp_series(input u64_t f);
    u64_t term;
    u64_t total;
    u64_t step;
    term  = Q30_ONE;
    total = Q30_ONE;
    for (int k = 1; k <= 24; k++) begin
      step = u64_t'(k);
      term = ((term * f) >> 30) / step;
      if (k % 2 == 1) begin
        total = total - term;
      end else begin
        total = total + term;
      end
    end
    return total;
  endfunction

  // Entry i holds exp(-16*i/depth) in Q0.16. The exponent is split into
  // whole units, each applied as a rounded multiply by exp(-1), and a
  // fraction that goes through the series.
  initial begin : build_falloff_table
    u64_t e1;
    u64_t expo;
    u64_t whole;
    u64_t v;
    u64_t q;
    e1 = exp_series(Q30_ONE);
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      expo  = (u64_t'(i) << 34) / u64_t'(EXP_TABLE_DEPTH);
      whole = expo >> 30;
      v     = exp_series(expo & (Q30_ONE - 64'd1));
      for (u64_t j = 0; j < whole; j++) begin
        v = (v * e1 + (Q30_ONE >> 1)) >> 30;
      end
      q = (v + 64'd8192) >> 14;
      if (q > 64'd65535) begin
        q = 64'd65535;
      end
      falloff_table[i] = q[ROM_BITS-1:0];
    end
  end

  // Gray level expected for one pixel under the current register copy.
  // The sum is kept exact by scaling everything to a common denominator of
  // 2^24 * 100000, so truncation toward zero is a plain integer divide.
  function automatic logic [COLOR_BITS-1:0] predict_gray(input pixel_t px);
    u64_t   gray;
    u64_t   d2;
    u64_t   p;
    u64_t   shade;
    u64_t   glow;
    longint dx;
    longint dy;
    longint total;
    gray  = (11 * u64_t'(px.red) + 16 * u64_t'(px.green) + 5 * u64_t'(px.blue)) >> 5;
    dx    = longint'(px.x) - longint'(glow_cfg.center_x);
    dy    = longint'(px.y) - longint'(glow_cfg.center_y);
    d2    = u64_t'(dx * dx + dy * dy);
    p     = d2 * u64_t'(glow_cfg.falloff_scale);
    shade = 0;
    // Exponents of 16 and above fall off the end of the table to zero.
    // Below that, the index is the exponent's top bits under 2^36.
    if (p < EXP_SATURATION) begin
      shade = u64_t'(falloff_table[p[EXP_SAT_BIT-1 -: IDX_BITS]]);
    end
    glow  = shade * u64_t'(glow_cfg.glow_peak);
    total = longint'(gray) * GLOW_ONE * NOISE_SPAN
          + longint'(glow) * NOISE_SPAN
          + (longint'(px.noise) - NOISE_ZERO) * GRAY_MAX * GLOW_ONE;
    if (total <= 0) begin
      return '0;
    end
    total = total / (GLOW_ONE * NOISE_SPAN);
    if (total > GRAY_MAX) begin
      total = GRAY_MAX;
    end
    return total[COLOR_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // The sink stalls on its own random schedule, independent of out_valid.
  always @(posedge clk) begin
    out_stall <= pace_idle && ($urandom_range(99) < IDLE_PERCENT);
  end

  // Every accepted gray item is matched against the oldest pixel in flight.
  always @(posedge clk) begin : check_gray
    gray_expect_t head;
    if (!rst && out_valid && !out_stall) begin
      if (gray_expected_q.size() == 0) begin
        report_mismatch($sformatf("gray item %0d arrived with no pixel in flight",
                                  gray_out));
      end else begin
        head = gray_expected_q.pop_front();
        results_seen++;
        if (gray_out !== head.gray) begin
          report_mismatch($sformatf(
            "item %0d rgb %0d/%0d/%0d at (%0d,%0d) noise %0d: gray %0d, wanted %0d",
            head.serial, head.px.red, head.px.green, head.px.blue, head.px.x,
            head.px.y, head.px.noise, gray_out, head.gray));
        end
      end
    end
  end

  // Offers one pixel item and returns at the edge that accepts it. Idle
  // cycles before the item are decided one at a time so gaps have random
  // length; valid stays high between back-to-back items.
  task automatic send_pixel(input pixel_t px);
    while (pace_idle && ($urandom_range(99) < IDLE_PERCENT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_red   <= px.red;
    pixel_green <= px.green;
    pixel_blue  <= px.blue;
    pixel_x     <= px.x;
    pixel_y     <= px.y;
    noise_code  <= px.noise;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    gray_expected_q.push_back('{items_sent, px, predict_gray(px)});
    items_sent++;
  endtask

  // Stops the source and waits until every pixel in flight has come back,
  // then lets the pipeline settle. A stuck pipeline is reported and its pending predictions are dropped.
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (gray_expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (gray_expected_q.size() != 0) begin
      report_mismatch($sformatf("%0d pixel items never produced a gray item",
                                gray_expected_q.size()));
      gray_expected_q.delete();
    end
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  // One register write; the predictor's copy follows the register widths
  // and ignores indexes past the last register, as the block does.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    case (index)
      REG_CENTER_X:      glow_cfg.center_x      = value[FIELD_BITS-1:0];
      REG_CENTER_Y:      glow_cfg.center_y      = value[FIELD_BITS-1:0];
      REG_FALLOFF_SCALE: glow_cfg.falloff_scale = value[SCALE_BITS-1:0];
      REG_GLOW_PEAK:     glow_cfg.glow_peak     = value[PEAK_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [CFG_DATA_BITS-1:0] cx_word,
                               input logic [CFG_DATA_BITS-1:0] cy_word,
                               input logic [CFG_DATA_BITS-1:0] scale_word,
                               input logic [CFG_DATA_BITS-1:0] peak_word);
    wait_idle();
    write_reg(REG_CENTER_X, cx_word);
    write_reg(REG_CENTER_Y, cy_word);
    write_reg(REG_FALLOFF_SCALE, scale_word);
    write_reg(REG_GLOW_PEAK, peak_word);
    cfg_write <= 1'b0;
    settings_applied++;
  endtask

  function automatic pixel_t make_pixel(input logic [COLOR_BITS-1:0] r,
                                        input logic [COLOR_BITS-1:0] g,
                                        input logic [COLOR_BITS-1:0] b,
                                        input logic [FIELD_BITS-1:0] x,
                                        input logic [FIELD_BITS-1:0] y,
                                        input logic [FIELD_BITS-1:0] noise);
    pixel_t px;
    px.red   = r;
    px.green = g;
    px.blue  = b;
    px.x     = x;
    px.y     = y;
    px.noise = noise;
    return px;
  endfunction

  // Mostly any color, now and then a component pinned to an extreme.
  function automatic logic [COLOR_BITS-1:0] pick_color();
    if ($urandom_range(9) == 0) begin
      return $urandom_range(1) ? COLOR_FULL : '0;
    end
    return COLOR_BITS'($urandom);
  endfunction

  // Registers as they come out of reset: the scale is zero, so the glow is
  // at full table value everywhere, but the peak is zero too. This checks
  // gray conversion, the noise offset at its ends and both clamps.
  task automatic test_reset_defaults();
    send_pixel(make_pixel('0, '0, '0, '0, '0, '0));
    send_pixel(make_pixel(COLOR_FULL, COLOR_FULL, COLOR_FULL, COORD_MAX, COORD_MAX, '1));
    send_pixel(make_pixel(COLOR_FULL, '0, '0, COORD_MAX, '0, NOISE_NONE));
    send_pixel(make_pixel('0, COLOR_FULL, '0, '0, COORD_MAX, NOISE_TOP));
    send_pixel(make_pixel('0, '0, COLOR_FULL, COORD_MAX, COORD_MAX, NOISE_NONE));
    // A hair below zero noise must truncate toward zero, not round down.
    send_pixel(make_pixel(8'd128, 8'd128, 8'd128, 12'd7, 12'd9, NOISE_NONE - 12'd1));
  endtask

  // The glow profile: the center, points along the falloff, the edge of
  // the table where the exponent saturates, zero scale and full peak.
  task automatic test_glow_shape();
    // Radius of about 50 pixels to an exponent of 16, peak of 64 levels.
    apply_setting(32'd100, 32'd200, 32'd27487790, 32'h0000_4000);
    // At the center the table gives 65535, just short of one.
    send_pixel(make_pixel('0, '0, '0, 12'd100, 12'd200, NOISE_NONE));
    send_pixel(make_pixel(8'd40, 8'd90, 8'd10, 12'd110, 12'd205, NOISE_NONE));
    send_pixel(make_pixel(8'd40, 8'd90, 8'd10, 12'd125, 12'd200, 12'd1500));
    send_pixel(make_pixel(8'd40, 8'd90, 8'd10, 12'd100, 12'd250, NOISE_TOP));
    send_pixel(make_pixel(8'd40, 8'd90, 8'd10, '0, '0, NOISE_NONE));
    // Largest scale and peak: a squared distance of 16 lands on the last
    // table entry, 17 is saturated, and the center's glow reaches the top level.
    apply_setting(32'd0, 32'd0, SCALE_MAX, PEAK_MAX);
    send_pixel(make_pixel('0, '0, '0, 12'd4, 12'd0, NOISE_NONE));
    send_pixel(make_pixel('0, '0, '0, 12'd4, 12'd1, NOISE_NONE));
    send_pixel(make_pixel('0, '0, '0, 12'd0, 12'd0, NOISE_NONE));
    send_pixel(make_pixel('0, '0, '0, 12'd0, 12'd0, '0));
    // Center in the far corner: the largest distance there is.
    apply_setting(COORD_MAX, COORD_MAX, SCALE_MAX, PEAK_MAX);
    send_pixel(make_pixel(COLOR_FULL, '0, COLOR_FULL, '0, '0, NOISE_NONE));
    // Zero scale gives the full table value at every position.
    apply_setting(32'd2048, 32'd1024, 32'd0, 32'h0000_0100);
    send_pixel(make_pixel(8'd200, 8'd100, 8'd50, '0, COORD_MAX, NOISE_NONE));
    send_pixel(make_pixel(8'd200, 8'd100, 8'd50, 12'd2048, 12'd1024, NOISE_NONE));
  endtask

  // Register data wider than a register must be cut to its width, and
  // writes to indexes past the last register must change nothing. The
  // stray writes follow the four real ones without a break in the enable.
  task automatic test_register_writes();
    wait_idle();
    write_reg(REG_CENTER_X, 32'hFFFF_F010);
    write_reg(REG_CENTER_Y, 32'hABCD_E020);
    write_reg(REG_FALLOFF_SCALE, 32'h0100_0000);
    write_reg(REG_GLOW_PEAK, 32'hDEAD_8000);
    for (int idx = REG_GLOW_PEAK + 1; idx < 2 ** CFG_INDEX_BITS; idx++) begin
      write_reg(CFG_INDEX_BITS'(idx), $urandom);
    end
    cfg_write <= 1'b0;
    settings_applied++;
    send_pixel(make_pixel(8'd60, 8'd60, 8'd60, 12'h010, 12'h020, NOISE_NONE));
    send_pixel(make_pixel(8'd60, 8'd60, 8'd60, 12'h030, 12'h000, NOISE_NONE));
    send_pixel(make_pixel(8'd60, 8'd60, 8'd60, COORD_MAX, 12'h020, NOISE_NONE));
  endtask

  // Random pixels over a series of register settings. Most pixels sit
  // within a few radii of the center, where the falloff actually varies;
  // the rest roam the whole frame. Several settings pin a register to an
  // extreme, and the first one runs with no idling on either side.
  task automatic test_random_stream(input int phases, input int per_phase);
    int                    radius;
    int                    off;
    u64_t                  scale;
    logic [FIELD_BITS-1:0] cx;
    logic [FIELD_BITS-1:0] cy;
    logic [PEAK_BITS-1:0]  peak;
    pixel_t                px;
    for (int phase = 0; phase < phases; phase++) begin
      cx     = FIELD_BITS'($urandom);
      cy     = FIELD_BITS'($urandom);
      radius = $urandom_range(4, 600);
      scale  = (u64_t'(1) << 36) / u64_t'(radius * radius);
      scale  = scale * u64_t'($urandom_range(1, 8)) / 4;
      if (scale > u64_t'(SCALE_MAX)) begin
        scale = u64_t'(SCALE_MAX);
      end
      peak = PEAK_BITS'($urandom);
      case (phase)
        1: scale = 0;
        2: begin
          scale  = u64_t'(SCALE_MAX);
          radius = 4;
        end
        3: peak = '0;
        4: peak = PEAK_MAX;
        5: begin
          cx = '0;
          cy = '0;
        end
        6: begin
          cx = COORD_MAX;
          cy = COORD_MAX;
        end
        default: ;
      endcase
      // Upper data bits are random: they must never reach the centers.
      apply_setting({20'($urandom), cx}, {20'($urandom), cy},
                    scale[CFG_DATA_BITS-1:0], {16'($urandom), peak});
      pace_idle = (phase != 0);
      for (int n = 0; n < per_phase; n++) begin
        px.red   = pick_color();
        px.green = pick_color();
        px.blue  = pick_color();
        if ($urandom_range(99) < 70) begin
          off  = int'($urandom_range(0, 4 * radius)) - 2 * radius;
          px.x = FIELD_BITS'(int'(cx) + off);
          off  = int'($urandom_range(0, 4 * radius)) - 2 * radius;
          px.y = FIELD_BITS'(int'(cy) + off);
        end else begin
          px.x = FIELD_BITS'($urandom);
          px.y = FIELD_BITS'($urandom);
        end
        case ($urandom_range(19))
          0:       px.noise = NOISE_NONE;
          1, 2:    px.noise = FIELD_BITS'($urandom_range(int'(NOISE_TOP) + 1, 4095));
          default: px.noise = FIELD_BITS'($urandom_range(0, int'(NOISE_TOP)));
        endcase
        send_pixel(px);
      end
      pace_idle = 1'b1;
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_glow_shape();
    test_register_writes();
    test_random_stream(9, 120);
    wait_idle();
    $display("Summary: %0d gray items compared against prediction over %0d register settings.",
             results_seen, settings_applied);
    $display("Summary: %0d pixel items sent, %0d mismatches reported.",
             items_sent, mismatches);
    if (mismatches == 0) begin
      $display("radial_glow_overlay_pixel regression: pass");
    end else begin
      $display("radial_glow_overlay_pixel regression: fail");
    end
    $finish;
  end

  // Hard stop for a hung pipeline, far beyond the slowest legal run.
  initial begin
    #(4_000_000);
    $display("radial_glow_overlay_pixel regression: fail");
    $finish;
  end

endmodule
